/* rtl/msort_pkg.sv */
`timescale 1ns / 1ps

package msort_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int DATA_WIDTH       = 32;

   // controller -> datapath
   typedef struct packed {
      logic fill;
      logic start;
      logic merge;
      logic emit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic block_done;   // last value of a block taken
      logic single;       // block holds at most one value, nothing to merge
      logic sort_done;    // final merge pass finished
      logic emit_done;    // last result taken
   } dp_status_type;

endpackage

/* rtl/msort_ram.sv */
`timescale 1ns / 1ps

module msort_ram #(
   parameter int WIDTH = msort_pkg::DATA_WIDTH,
   parameter int DEPTH = msort_pkg::CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // write-first: a read of the address being written returns the new data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem_ff[rd_addr_a];
      rd_data_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/msort_ctrl.sv */
`timescale 1ns / 1ps

module msort_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  msort_pkg::dp_status_type status,
   output msort_pkg::ctrl_cmd_type  cmd,
   output logic                     req_stall,
   output logic                     rsp_valid
);

   typedef enum logic [3:0] {
      ST_FILL  = 4'b0001,
      ST_START = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (status.block_done) state_in = ST_START;
         end
         ST_START: begin
            state_in = status.single ? ST_EMIT : ST_MERGE;
         end
         ST_MERGE: begin
            if (status.sort_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.emit_done) state_in = ST_FILL;
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.fill  = (state_ff == ST_FILL);
   assign cmd.start = (state_ff == ST_START);
   assign cmd.merge = (state_ff == ST_MERGE);
   assign cmd.emit  = (state_ff == ST_EMIT);

   assign req_stall = (state_ff != ST_FILL);
   assign rsp_valid = (state_ff == ST_EMIT);

endmodule

/* rtl/msort_datapath.sv */
`timescale 1ns / 1ps

module msort_datapath #(
   parameter int CAPACITY = msort_pkg::CAPACITY_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  msort_pkg::ctrl_cmd_type                cmd,
   output msort_pkg::dp_status_type               status,
   input  logic                                   req_valid,
   input  logic signed [msort_pkg::DATA_WIDTH-1:0] req_element_value,
   input  logic                                   req_block_end,
   input  logic                                   rsp_stall,
   output logic signed [msort_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                                   rsp_final_item,
   output logic                                   rsp_overflow_dropped
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = CW + 1;
   localparam int SW = CW + 2;
   localparam int DW = msort_pkg::DATA_WIDTH;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);
   localparam logic [WW-1:0] ONE_WID = WW'(1);

   logic [CW-1:0] fill_ff, fill_in;
   logic          ovf_ff, ovf_in;
   logic [WW-1:0] width_ff, width_in;
   logic          src_sel_ff, src_sel_in;   // 0: bank A holds the current runs
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;

   logic          req_acc, rsp_acc;
   logic          a_we, b_we;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [DW-1:0] a_q_a, a_q_b, b_q_a, b_q_b;
   logic signed [DW-1:0] head_a, head_b, merged;
   logic          a_ok, b_ok, take_a;
   logic          seg_end, pass_done, last_item;
   logic [WW-1:0] width_dbl;
   logic [CW-1:0] seg_lo;
   logic [WW-1:0] seg_w;
   logic [SW-1:0] mid_sum, hi_sum;
   logic [CW-1:0] seg_mid, seg_hi;

   assign req_acc = cmd.fill & req_valid;
   assign rsp_acc = cmd.emit & ~rsp_stall;

   // read ports follow the next index so the registered heads line up with the current indices
   msort_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_bank_a (
      .clock     (clock),
      .wr_en     (a_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (i_in[AW-1:0]),
      .rd_addr_b (j_in[AW-1:0]),
      .rd_data_a (a_q_a),
      .rd_data_b (a_q_b)
   );

   msort_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_bank_b (
      .clock     (clock),
      .wr_en     (b_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (i_in[AW-1:0]),
      .rd_addr_b (j_in[AW-1:0]),
      .rd_data_a (b_q_a),
      .rd_data_b (b_q_b)
   );

   assign head_a = src_sel_ff ? b_q_a : a_q_a;
   assign head_b = src_sel_ff ? b_q_b : a_q_b;

   // left run wins ties to keep the sort stable
   assign a_ok   = (i_ff < mid_ff);
   assign b_ok   = (j_ff < hi_ff);
   assign take_a = a_ok && (!b_ok || (head_a <= head_b));
   assign merged = take_a ? head_a : head_b;

   assign seg_end   = ((k_ff + ONE_CNT) == hi_ff);
   assign pass_done = cmd.merge && seg_end && (hi_ff == fill_ff);
   assign width_dbl = {width_ff[WW-2:0], 1'b0};
   assign last_item = ((i_ff + ONE_CNT) == fill_ff);

   // bounds of the next pair of runs, clipped to the block length
   assign seg_lo  = (cmd.start || pass_done) ? '0 : hi_ff;
   assign seg_w   = cmd.start ? ONE_WID : (pass_done ? width_dbl : width_ff);
   assign mid_sum = SW'(seg_lo) + SW'(seg_w);
   assign hi_sum  = mid_sum + SW'(seg_w);
   assign seg_mid = (mid_sum > SW'(fill_ff)) ? fill_ff : mid_sum[CW-1:0];
   assign seg_hi  = (hi_sum > SW'(fill_ff)) ? fill_ff : hi_sum[CW-1:0];

   always_comb begin
      fill_in    = fill_ff;
      ovf_in     = ovf_ff;
      width_in   = width_ff;
      src_sel_in = src_sel_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      a_we       = 1'b0;
      b_we       = 1'b0;
      wr_addr    = fill_ff[AW-1:0];
      wr_data    = req_element_value;

      if (req_acc) begin
         if (fill_ff < CAP_CNT) begin
            a_we    = 1'b1;
            fill_in = fill_ff + ONE_CNT;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.start) begin
         width_in   = ONE_WID;
         src_sel_in = 1'b0;
         i_in       = seg_lo;
         j_in       = seg_mid;
         k_in       = seg_lo;
         mid_in     = seg_mid;
         hi_in      = seg_hi;
      end

      if (cmd.merge) begin
         wr_addr = k_ff[AW-1:0];
         wr_data = merged;
         a_we    = src_sel_ff;
         b_we    = ~src_sel_ff;
         k_in    = k_ff + ONE_CNT;
         if (take_a) begin
            i_in = i_ff + ONE_CNT;
         end else begin
            j_in = j_ff + ONE_CNT;
         end
         if (seg_end) begin
            // after the final pass this also leaves i at zero for output
            i_in   = seg_lo;
            j_in   = seg_mid;
            k_in   = seg_lo;
            mid_in = seg_mid;
            hi_in  = seg_hi;
            if (pass_done) begin
               width_in   = width_dbl;
               src_sel_in = ~src_sel_ff;
            end
         end
      end

      if (rsp_acc) begin
         if (last_item) begin
            fill_in = '0;
            ovf_in  = 1'b0;
         end else begin
            i_in = i_ff + ONE_CNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         ovf_ff     <= 1'b0;
         width_ff   <= ONE_WID;
         src_sel_ff <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         mid_ff     <= '0;
         hi_ff      <= '0;
      end else begin
         fill_ff    <= fill_in;
         ovf_ff     <= ovf_in;
         width_ff   <= width_in;
         src_sel_ff <= src_sel_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         k_ff       <= k_in;
         mid_ff     <= mid_in;
         hi_ff      <= hi_in;
      end
   end

   assign status.block_done = req_acc & req_block_end;
   assign status.single     = (fill_ff <= ONE_CNT);
   assign status.sort_done  = pass_done && (width_dbl >= {1'b0, fill_ff});
   assign status.emit_done  = rsp_acc & last_item;

   assign rsp_sorted_value     = head_a;
   assign rsp_final_item       = last_item;
   assign rsp_overflow_dropped = ovf_ff;

endmodule

/* rtl/merge_sort_engine.sv */
`timescale 1ns / 1ps
// Intake: one value per cycle while the engine waits for a block.
// A block of n values is then sorted in merge passes: each merge pass writes one
// value per cycle through the dual-read-port banks, ping-ponging between them.
// Results stream out at one per cycle while rsp_stall is low, from the bank holding the sorted runs.
// Synchronous active-high reset clears control state; the two value banks are not cleared.

module merge_sort_engine #(
   parameter int CAPACITY = msort_pkg::CAPACITY_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [msort_pkg::DATA_WIDTH-1:0] req_element_value,
   input  logic                                    req_block_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [msort_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                                    rsp_final_item,
   output logic                                    rsp_overflow_dropped
);

   msort_pkg::ctrl_cmd_type  cmd;
   msort_pkg::dp_status_type status;

   msort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   msort_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_valid            (req_valid),
      .req_element_value    (req_element_value),
      .req_block_end        (req_block_end),
      .rsp_stall            (rsp_stall),
      .rsp_sorted_value     (rsp_sorted_value),
      .rsp_final_item       (rsp_final_item),
      .rsp_overflow_dropped (rsp_overflow_dropped)
   );

   // no intake while results are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during output");

   // end of block goes straight to sorting, nothing shown yet
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_block_end) |=> (req_stall && !rsp_valid))
      else $error("block end did not start the sort");

   // final transaction returns the engine to intake
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_final_item) |=> (!rsp_valid && !req_stall))
      else $error("engine did not return to intake after final result");

endmodule
